@@ hdl/gioc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gioc_pkg: shared types and constants of the grid index offset converter
// Beat formats of both channels, register indexes and pipeline geometry.
// ----------------------------------------------------------------------------
package gioc_pkg;

	localparam int NUM_DIMS   = 4;
	localparam int SIZE_W     = 16;
	localparam int INDEX_W    = 32;
	localparam int OFFSET_W   = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int DIV_STAGES = OFFSET_W;
	localparam int NUM_STAGES = NUM_DIMS * DIV_STAGES;

	localparam logic [CFG_IDX_W-1:0] REG_DIM_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_0    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_1    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_2    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_3    = 3'd4;

	localparam logic ACT_TO_OFFSET = 1'b0;
	localparam logic ACT_TO_COORD  = 1'b1;

	typedef struct packed {
		logic                action;
		logic [INDEX_W-1:0]  index_0;
		logic [INDEX_W-1:0]  index_1;
		logic [INDEX_W-1:0]  index_2;
		logic [INDEX_W-1:0]  index_3;
		logic [OFFSET_W-1:0] offset_in;
		logic [3:0]          ignore_mask;
	} in_beat_t;

	typedef struct packed {
		logic [OFFSET_W-1:0] offset_out;
		logic [SIZE_W-1:0]   coord_0;
		logic [SIZE_W-1:0]   coord_1;
		logic [SIZE_W-1:0]   coord_2;
		logic [SIZE_W-1:0]   coord_3;
	} out_beat_t;

	// One stage of the divider chain.
	typedef struct packed {
		logic                               action;
		logic [NUM_DIMS-1:0]                skip;
		logic [NUM_DIMS-1:0]                neg;
		logic [NUM_DIMS-1:0][INDEX_W-1:0]   mag;
		logic [NUM_DIMS-1:0][SIZE_W-1:0]    coord;
		logic [SIZE_W-1:0]                  rem;
		logic [OFFSET_W-1:0]                dq;
	} div_stage_t;

endpackage

@@ hdl/grid_index_offset_converter_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_index_offset_converter_top: grid coordinates to linear offset and back
// Wraps signed coordinates into range and forms the mixed-radix offset, or
// splits an offset into coordinates, dimension zero varying fastest.
// ----------------------------------------------------------------------------
// The block takes one beat per clock while the output is not stalled and
// returns one beat per input beat, in order. The pipeline is a chain of
// four restoring dividers, one per dimension, each resolving one quotient bit
// per stage over 64 stages, followed by three multiply-add stages that fold the
// coordinates into the offset. A stall on the output freezes the whole chain.
// Sizes and dimension count are read live, so write them only while idle.
module grid_index_offset_converter_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  gioc_pkg::in_beat_t         in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output gioc_pkg::out_beat_t        out_data,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [gioc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gioc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import gioc_pkg::*;

	logic [2:0]                       dim_count_q;
	logic [NUM_DIMS-1:0][SIZE_W-1:0]  size_q;
	logic [NUM_DIMS-1:0][SIZE_W-1:0]  eff_size;
	logic [2:0]                       used_dims;
	logic                             adv;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_count_q <= 3'd1;
			size_q      <= {NUM_DIMS{16'd1}};
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DIM_COUNT: dim_count_q <= cfg_data[2:0];
				REG_SIZE_0:    size_q[0]   <= cfg_data;
				REG_SIZE_1:    size_q[1]   <= cfg_data;
				REG_SIZE_2:    size_q[2]   <= cfg_data;
				REG_SIZE_3:    size_q[3]   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int d = 0; d < NUM_DIMS; d++)
			eff_size[d] = (size_q[d] == '0) ? 16'd1 : size_q[d];
		if (dim_count_q == 3'd0)
			used_dims = 3'd1;
		else if (dim_count_q > 3'(NUM_DIMS))
			used_dims = 3'(NUM_DIMS);
		else
			used_dims = dim_count_q;
	end

	// The chain moves as one; the output register decouples nothing but
	// keeps valid independent of the downstream stall.
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// A skipped dimension divides by one: its remainder is zero and the
	// quotient passes on unchanged.
	function automatic logic [SIZE_W-1:0] divisor(input logic skip,
			input logic [SIZE_W-1:0] sz);
		return skip ? 16'd1 : sz;
	endfunction

	// Turns |v| mod s into the non-negative modulo of a negative v.
	function automatic logic [SIZE_W-1:0] fix_sign(input logic act, input logic neg,
			input logic [SIZE_W-1:0] r, input logic [SIZE_W-1:0] dv);
		return (act == ACT_TO_OFFSET && neg && r != '0) ? dv - r : r;
	endfunction

	div_stage_t                  entry;
	div_stage_t                  pipe_s [NUM_STAGES];
	logic [NUM_STAGES-1:0]       vld_s;

	always_comb begin
		logic [NUM_DIMS-1:0][INDEX_W-1:0] raw;
		raw = {in_data.index_3, in_data.index_2, in_data.index_1, in_data.index_0};
		entry        = '0;
		entry.action = in_data.action;
		for (int d = 0; d < NUM_DIMS; d++) begin
			entry.neg[d]  = raw[d][INDEX_W-1];
			entry.mag[d]  = raw[d][INDEX_W-1] ? (~raw[d] + 32'd1) : raw[d];
			entry.skip[d] = (3'(d) >= used_dims) ||
				(in_data.action == ACT_TO_COORD && in_data.ignore_mask[d]);
		end
		entry.dq = (in_data.action == ACT_TO_OFFSET) ? {32'd0, entry.mag[0]}
			: in_data.offset_in;
	end

	for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
		localparam int D = k / DIV_STAGES;
		localparam int B = k % DIV_STAGES;
		div_stage_t           src;
		div_stage_t           nxt;
		logic                 src_vld;
		logic [SIZE_W-1:0]    dv;
		logic [SIZE_W:0]      r17;
		logic                 ge;

		if (k == 0) begin : g_first
			assign src     = entry;
			assign src_vld = in_valid;
		end else if (B == 0) begin : g_load
			// Close the previous dimension and load this one's dividend.
			always_comb begin
				src          = pipe_s[k-1];
				src.coord[D-1] = fix_sign(pipe_s[k-1].action, pipe_s[k-1].neg[D-1],
					pipe_s[k-1].rem, divisor(pipe_s[k-1].skip[D-1], eff_size[D-1]));
				src.rem      = '0;
				src.dq       = (pipe_s[k-1].action == ACT_TO_OFFSET)
					? {32'd0, pipe_s[k-1].mag[D]} : pipe_s[k-1].dq;
			end
			assign src_vld = vld_s[k-1];
		end else begin : g_mid
			assign src     = pipe_s[k-1];
			assign src_vld = vld_s[k-1];
		end

		always_comb begin
			dv      = divisor(src.skip[D], eff_size[D]);
			r17     = {src.rem, src.dq[OFFSET_W-1]};
			ge      = r17 >= {1'b0, dv};
			nxt     = src;
			nxt.rem = ge ? SIZE_W'(r17 - {1'b0, dv}) : r17[SIZE_W-1:0];
			nxt.dq  = {src.dq[OFFSET_W-2:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k] <= 1'b0;
			else if (adv)
				vld_s[k] <= src_vld;
		end

		always_ff @(posedge clk) begin
			if (adv)
				pipe_s[k] <= nxt;
		end
	end

	// Fold the coordinates into the offset, slowest dimension first.
	logic [NUM_DIMS-1:0][SIZE_W-1:0] last_coord;
	logic [NUM_DIMS-1:0][SIZE_W-1:0] coord_m1, coord_m2;
	logic [31:0]                     acc_m1;
	logic [47:0]                     acc_m2;
	logic                            act_m1, act_m2, act_q;
	logic                            vld_m1, vld_m2;

	always_comb begin
		last_coord    = pipe_s[NUM_STAGES-1].coord;
		last_coord[NUM_DIMS-1] = fix_sign(pipe_s[NUM_STAGES-1].action,
			pipe_s[NUM_STAGES-1].neg[NUM_DIMS-1], pipe_s[NUM_STAGES-1].rem,
			divisor(pipe_s[NUM_STAGES-1].skip[NUM_DIMS-1], eff_size[NUM_DIMS-1]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_m1    <= 1'b0;
			vld_m2    <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			vld_m1    <= vld_s[NUM_STAGES-1];
			vld_m2    <= vld_m1;
			out_valid <= vld_m2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			coord_m1 <= last_coord;
			act_m1   <= pipe_s[NUM_STAGES-1].action;
			acc_m1   <= 32'(last_coord[3]) * 32'(eff_size[2]) + 32'(last_coord[2]);
			coord_m2 <= coord_m1;
			act_m2   <= act_m1;
			acc_m2   <= 48'(acc_m1) * 48'(eff_size[1]) + 48'(coord_m1[1]);
			act_q    <= act_m2;
			out_data.offset_out <= (act_m2 == ACT_TO_COORD) ? 64'd0
				: 64'(acc_m2) * 64'(eff_size[0]) + 64'(coord_m2[0]);
			out_data.coord_0 <= coord_m2[0];
			out_data.coord_1 <= coord_m2[1];
			out_data.coord_2 <= coord_m2[2];
			out_data.coord_3 <= coord_m2[3];
		end
	end

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> vld_s[0])
		else $error("accepted beat did not enter the divider chain");

	a_coord0_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.coord_0 < eff_size[0])
		else $error("coordinate zero out of range");

	a_split_zero_offset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && act_q == ACT_TO_COORD |-> out_data.offset_out == 64'd0)
		else $error("offset not zero on a split beat");

endmodule

@@ sim/grid_index_offset_converter_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_index_offset_converter_top_test: self-checking bench of the converter
// Drives coordinate and offset beats under several grid configurations with
// random bursts and output stalls, and checks every result beat in order
// against a behavioral prediction of the wrap and mixed-radix arithmetic.
// ----------------------------------------------------------------------------
module grid_index_offset_converter_top_test;
	import gioc_pkg::*;

	localparam int LATENCY = 259;
	localparam longint CYCLE_LIMIT = 2000000;
	localparam int IN_W = $bits(in_beat_t);

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_beat_t in_data;
	logic out_valid;
	logic out_stall;
	out_beat_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	logic [2:0] dims_cfg;
	logic [SIZE_W-1:0] size_cfg [NUM_DIMS];
	out_beat_t expected_beats [$];
	int mismatch_count;
	int result_count;
	int beat_count;
	longint cycle_count;
	bit stall_quiet;

	grid_index_offset_converter_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic out_beat_t convert_beat(in_beat_t b);
		out_beat_t r;
		logic [SIZE_W-1:0] crd [NUM_DIMS];
		longint unsigned offs;
		longint unsigned hyper;
		longint signed v;
		longint signed s;
		longint signed m;
		int n;
		n = (dims_cfg == 0) ? 1 : (dims_cfg > NUM_DIMS ? NUM_DIMS : dims_cfg);
		for (int d = 0; d < NUM_DIMS; d++) crd[d] = '0;
		offs = 0;
		hyper = 1;
		if (b.action == ACT_TO_OFFSET) begin
			for (int d = 0; d < n; d++) begin
				case (d)
					0: v = $signed(b.index_0);
					1: v = $signed(b.index_1);
					2: v = $signed(b.index_2);
					default: v = $signed(b.index_3);
				endcase
				s = (size_cfg[d] == 0) ? 1 : size_cfg[d];
				m = v % s;
				if (m < 0) m += s;
				crd[d] = m[SIZE_W-1:0];
			end
			for (int d = n - 1; d >= 0; d--)
				offs = offs * ((size_cfg[d] == 0) ? 64'd1 : 64'(size_cfg[d])) + crd[d];
		end else begin
			for (int d = 0; d < n; d++) begin
				if (!b.ignore_mask[d]) begin
					s = (size_cfg[d] == 0) ? 1 : size_cfg[d];
					crd[d] = SIZE_W'((b.offset_in / hyper) % longint'(s));
					hyper = hyper * longint'(s);
				end
			end
		end
		r.offset_out = offs;
		r.coord_0 = crd[0];
		r.coord_1 = crd[1];
		r.coord_2 = crd[2];
		r.coord_3 = crd[3];
		return r;
	endfunction

	// Output side: stall pattern and in-order comparison.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			result_count++;
			if (expected_beats.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("Unexpected result beat %h", out_data);
			end else begin
				out_beat_t e;
				e = expected_beats.pop_front();
				if (e !== out_data) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("Mismatch at beat %0d: expected %h got %h",
							result_count, e, out_data);
				end
			end
		end
	end

	always @(negedge clk) begin
		if (stall_quiet || cycle_count[9])
			out_stall <= 1'b0;
		else
			out_stall <= ($urandom_range(0, 3) == 0);
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_DIM_COUNT) dims_cfg = val[2:0];
		else size_cfg[idx - 1] = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_beat(in_beat_t b);
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= b;
		do @(posedge clk); while (in_stall);
		expected_beats.push_back(convert_beat(b));
		beat_count++;
	endtask

	task automatic go_idle();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic drain();
		go_idle();
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_grid(int n, int s0, int s1, int s2, int s3);
		write_reg(REG_DIM_COUNT, CFG_DATA_W'(n));
		write_reg(REG_SIZE_0, CFG_DATA_W'(s0));
		write_reg(REG_SIZE_1, CFG_DATA_W'(s1));
		write_reg(REG_SIZE_2, CFG_DATA_W'(s2));
		write_reg(REG_SIZE_3, CFG_DATA_W'(s3));
	endtask

	function automatic in_beat_t random_beat(int bias);
		in_beat_t b;
		b = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
		b.action = 1'($urandom_range(0, 1));
		if (bias != 0 && $urandom_range(0, 1)) begin
			b.index_0 = $signed($urandom_range(0, 80)) - 40;
			b.index_1 = $signed($urandom_range(0, 80)) - 40;
			b.offset_in = 64'($urandom_range(0, 100000));
		end
		return b;
	endfunction

	task automatic test_directed();
		in_beat_t b;
		logic [31:0] edge_vals [6] = '{32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'd65535, 32'h5A5A_A5A5};
		set_grid(4, 65535, 65535, 65535, 65535);
		for (int i = 0; i < 6; i++) begin
			b = '0;
			b.action = ACT_TO_OFFSET;
			b.index_0 = edge_vals[i];
			b.index_1 = edge_vals[5 - i];
			b.index_2 = edge_vals[(i + 2) % 6];
			b.index_3 = edge_vals[(i + 4) % 6];
			b.ignore_mask = 4'hF;
			send_beat(b);
		end
		for (int i = 0; i < 6; i++) begin
			b = '0;
			b.action = ACT_TO_COORD;
			b.offset_in = (i == 0) ? 64'hFFFF_FFFF_FFFF_FFFF : {edge_vals[i], edge_vals[5 - i]};
			b.ignore_mask = 4'(i * 3);
			send_beat(b);
		end
		drain();
		// Zero sizes act as one, a zero dimension count acts as one.
		set_grid(0, 0, 0, 7, 0);
		for (int i = 0; i < 4; i++) send_beat(random_beat(0));
		drain();
		set_grid(7, 3, 0, 5, 2);
		for (int i = 0; i < 6; i++) begin
			b = random_beat(1);
			b.ignore_mask = 4'(i);
			send_beat(b);
		end
		drain();
	endtask

	task automatic test_random(int n, int s0, int s1, int s2, int s3, int count);
		int burst;
		set_grid(n, s0, s1, s2, s3);
		while (count > 0) begin
			burst = $urandom_range(1, 30);
			for (int i = 0; i < burst && count > 0; i++, count--)
				send_beat(random_beat(1));
			if ($urandom_range(0, 2) != 0) begin
				go_idle();
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cycle_count = 0;
		mismatch_count = 0;
		result_count = 0;
		beat_count = 0;
		stall_quiet = 1'b0;
		dims_cfg = 3'd1;
		for (int d = 0; d < NUM_DIMS; d++) size_cfg[d] = 16'd1;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random(1, 1000, 1, 1, 1, 150);
		test_random(2, 17, 300, 1, 1, 200);
		test_random(3, 5, 9, 13, 1, 200);
		test_random(4, 3, 1, 65535, 2, 200);
		test_random(4, $urandom_range(1, 65535), $urandom_range(1, 65535),
			$urandom_range(1, 65535), $urandom_range(1, 65535), 200);
		stall_quiet = 1'b1;
		test_random(4, 2, 3, 4, 5, 200);
		stall_quiet = 1'b0;

		go_idle();
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		$display("Covered %0d beats over nine grid settings, both actions, all masks.",
			beat_count);
		$display("Result beats checked: %0d, mismatches: %0d.", result_count, mismatch_count);
		if (mismatch_count == 0 && expected_beats.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
